// ===== src/two_layer_shortest_path_max_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef TWO_LAYER_SHORTEST_PATH_MAX_TOP_DEFINES_SVH
`define TWO_LAYER_SHORTEST_PATH_MAX_TOP_DEFINES_SVH

// Same-cycle implication, reset masked.
`define TLSP_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, reset masked.
`define TLSP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/tlsp_pkg.sv =====
package tlsp_pkg;

  localparam int MAX_NODES_D  = 256;
  localparam int MAX_EDGES_D  = 1024;
  localparam int DIST_WIDTH_D = 48;
  localparam int OUT_W        = 48;
  localparam int NODE_CNT_W   = 9;
  localparam logic [NODE_CNT_W-1:0] NODE_CNT_RST = 9'd256;

  localparam logic [1:0] OP_EDGE = 2'd0;
  localparam logic [1:0] OP_COST = 2'd1;
  localparam logic [1:0] OP_RUN  = 2'd2;

  // Datapath actions issued by the controller
  localparam logic [3:0] ACT_NOP       = 4'd0;
  localparam logic [3:0] ACT_LOAD_EDGE = 4'd1;
  localparam logic [3:0] ACT_LOAD_COST = 4'd2;
  localparam logic [3:0] ACT_INIT_CLR  = 4'd3;
  localparam logic [3:0] ACT_INIT_RD   = 4'd4;
  localparam logic [3:0] ACT_INIT_WR   = 4'd5;
  localparam logic [3:0] ACT_SCAN_CLR  = 4'd6;
  localparam logic [3:0] ACT_SCAN      = 4'd7;
  localparam logic [3:0] ACT_MARK      = 4'd8;
  localparam logic [3:0] ACT_EFETCH    = 4'd9;
  localparam logic [3:0] ACT_SLOT      = 4'd10;
  localparam logic [3:0] ACT_RLX       = 4'd11;
  localparam logic [3:0] ACT_MAX_CLR   = 4'd12;
  localparam logic [3:0] ACT_MAX       = 4'd13;
  localparam logic [3:0] ACT_DONE      = 4'd14;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  node_a;
    logic [7:0]  node_b;
    logic [31:0] weight;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] longest_distance;
    logic             edges_dropped;
  } out_t;

  typedef struct packed {
    logic [3:0] act;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic init_last;
    logic sweep_done;
    logic found;
    logic edges_done;
    logic slot_act;
    logic slot_last;
    logic slot_end;
  } stat_t;

endpackage

// ===== src/two_layer_shortest_path_max_top.sv =====
// Edge and start-cost loads: accepted one per cycle while idle, no result.
// Run: after the accept, distance setup over both layers, then per settled
// node a sweep, a mark and a walk of the edge list (fetch, then six relax
// slots per stored edge), a last sweep that finds nothing, a sweep for the
// maximum and a register stage for the result. Synchronous active-low reset
// clears control state, node count to 256, edge count and drop flag; stores
// are not cleared.
module two_layer_shortest_path_max_top #(
  parameter int MAX_NODES  = tlsp_pkg::MAX_NODES_D,
  parameter int MAX_EDGES  = tlsp_pkg::MAX_EDGES_D,
  parameter int DIST_WIDTH = tlsp_pkg::DIST_WIDTH_D
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tlsp_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tlsp_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlsp_pkg::NODE_CNT_W-1:0] cfg_data
);
  import tlsp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tlsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tlsp_dpath #(
    .MAX_NODES  (MAX_NODES),
    .MAX_EDGES  (MAX_EDGES),
    .DIST_WIDTH (DIST_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== src/tlsp_ctrl.sv =====
module tlsp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_op,
  output logic           in_ready,
  input  tlsp_pkg::stat_t stat,
  output tlsp_pkg::cmd_t  cmd
);
  import tlsp_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INIT_RD  = 4'd1;
  localparam logic [3:0] S_INIT_WR  = 4'd2;
  localparam logic [3:0] S_SCAN_CLR = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_MARK     = 4'd5;
  localparam logic [3:0] S_EFETCH   = 4'd6;
  localparam logic [3:0] S_SLOT     = 4'd7;
  localparam logic [3:0] S_RLX      = 4'd8;
  localparam logic [3:0] S_MAX_CLR  = 4'd9;
  localparam logic [3:0] S_MAX      = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state_r, state_nxt;

  // Take loads any time idle; hold a run until the result register is free
  assign in_ready = (state_r == S_IDLE) && (!stat.out_busy || in_op != OP_RUN);

  always_comb begin
    state_nxt = state_r;
    cmd.act   = ACT_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_op)
            OP_EDGE: cmd.act = ACT_LOAD_EDGE;
            OP_COST: cmd.act = ACT_LOAD_COST;
            OP_RUN: begin
              cmd.act   = ACT_INIT_CLR;
              state_nxt = S_INIT_RD;
            end
            default: cmd.act = ACT_NOP;
          endcase
        end
      end
      S_INIT_RD: begin
        cmd.act   = ACT_INIT_RD;
        state_nxt = S_INIT_WR;
      end
      S_INIT_WR: begin
        cmd.act   = ACT_INIT_WR;
        state_nxt = stat.init_last ? S_SCAN_CLR : S_INIT_RD;
      end
      S_SCAN_CLR: begin
        cmd.act   = ACT_SCAN_CLR;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.act = ACT_SCAN;
        if (stat.sweep_done) begin
          state_nxt = stat.found ? S_MARK : S_MAX_CLR;
        end
      end
      S_MARK: begin
        cmd.act   = ACT_MARK;
        state_nxt = S_EFETCH;
      end
      S_EFETCH: begin
        if (stat.edges_done) begin
          state_nxt = S_SCAN_CLR;
        end else begin
          cmd.act   = ACT_EFETCH;
          state_nxt = S_SLOT;
        end
      end
      S_SLOT: begin
        cmd.act = ACT_SLOT;
        if (stat.slot_act) begin
          state_nxt = S_RLX;
        end else if (stat.slot_last) begin
          state_nxt = S_EFETCH;
        end
      end
      S_RLX: begin
        cmd.act   = ACT_RLX;
        state_nxt = stat.slot_end ? S_EFETCH : S_SLOT;
      end
      S_MAX_CLR: begin
        cmd.act   = ACT_MAX_CLR;
        state_nxt = S_MAX;
      end
      S_MAX: begin
        cmd.act = ACT_MAX;
        if (stat.sweep_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.act   = ACT_DONE;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/tlsp_dpath.sv =====
module tlsp_dpath #(
  parameter int MAX_NODES  = tlsp_pkg::MAX_NODES_D,
  parameter int MAX_EDGES  = tlsp_pkg::MAX_EDGES_D,
  parameter int DIST_WIDTH = tlsp_pkg::DIST_WIDTH_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tlsp_pkg::in_t                 in_data,
  input  logic                          cfg_valid,
  input  logic [tlsp_pkg::NODE_CNT_W-1:0] cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output tlsp_pkg::out_t                out_data,
  input  tlsp_pkg::cmd_t                cmd,
  output tlsp_pkg::stat_t               stat
);
  import tlsp_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int DA_W   = NODE_W + 1;
  localparam int IW     = DA_W + 1;
  localparam int NW     = $clog2(MAX_NODES + 1);
  localparam int XW     = (DA_W > 9) ? DA_W : 9;
  localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W   = $clog2(MAX_EDGES + 1);
  localparam int DW     = DIST_WIDTH;
  localparam logic [DW-1:0] DMAX = '1;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  b;
    logic [31:0] w;
  } edge_t;

  typedef struct packed {
    logic          vis;
    logic [DW-1:0] d;
  } dword_t;

  // Storage
  edge_t       edge_mem [MAX_EDGES];
  logic [31:0] cost_mem [MAX_NODES];
  dword_t      dist_mem [2*MAX_NODES];

  logic [NODE_CNT_W-1:0] node_r;
  logic [EC_W-1:0]       ecnt_r;
  logic                  ovf_r;
  logic                  out_valid_r;
  out_t                  out_data_r;

  logic [IW-1:0]   idx_r;
  logic [DA_W-1:0] idx_d_r;
  logic            vld_d_r;
  logic [31:0]     sc_q;
  dword_t          dq;
  edge_t           eq;
  logic [EC_W-1:0] e_r;
  logic [2:0]      slot_r;
  logic [DW-1:0]   pd_r;
  logic [DA_W-1:0] pick_r;
  logic            found_r;
  logic [DA_W-1:0] tgt_r;
  logic [DW-1:0]   cand_r;
  logic [DW-1:0]   best_r;
  logic [OUT_W-1:0] best_o;

  // Effective node count: zero acts as one, clamp at capacity
  logic [NW-1:0] n_eff;
  logic [IW-1:0] n_i, two_n;
  assign n_eff = (node_r == '0) ? NW'(1) :
                 (32'(node_r) > MAX_NODES) ? NW'(MAX_NODES) : NW'(node_r);
  assign n_i   = IW'(n_eff);
  assign two_n = IW'({n_eff, 1'b0});

  // Relaxation targets of the current edge for the picked node
  logic [XW-1:0] n_x, a_x, b_x, pick_x, pl_x;
  logic          low, ok, ma, mb, s_act;
  logic [XW-1:0] s_tgt;
  logic [DW-1:0] s_cand, sat;
  logic [DW:0]   sum;

  assign n_x    = XW'(n_eff);
  assign a_x    = XW'(eq.a);
  assign b_x    = XW'(eq.b);
  assign pick_x = XW'(pick_r);
  assign low    = pick_x < n_x;
  assign pl_x   = low ? pick_x : pick_x - n_x;
  assign ok     = (a_x < n_x) && (b_x < n_x);
  assign ma     = ok && (pl_x == a_x);
  assign mb     = ok && (pl_x == b_x);
  assign sum    = {1'b0, pd_r} + (DW+1)'(eq.w);
  assign sat    = sum[DW] ? DMAX : sum[DW-1:0];

  always_comb begin
    s_act  = 1'b0;
    s_tgt  = a_x;
    s_cand = pd_r;
    case (slot_r)
      3'd0: begin
        s_act  = ma;
        s_tgt  = low ? b_x : b_x + n_x;
        s_cand = sat;
      end
      3'd1: begin
        s_act = ma && low;
        s_tgt = a_x + n_x;
      end
      3'd2: begin
        s_act = ma && low;
        s_tgt = b_x + n_x;
      end
      3'd3: begin
        s_act  = mb;
        s_tgt  = low ? a_x : a_x + n_x;
        s_cand = sat;
      end
      3'd4: begin
        s_act = mb && low;
        s_tgt = b_x + n_x;
      end
      3'd5: begin
        s_act = mb && low;
        s_tgt = a_x + n_x;
      end
      default: s_act = 1'b0;
    endcase
  end

  // Distance memory ports
  logic            d_re, d_we;
  logic [DA_W-1:0] d_raddr, d_waddr;
  dword_t          d_wdata;

  always_comb begin
    d_re    = 1'b0;
    d_raddr = idx_r[DA_W-1:0];
    d_we    = 1'b0;
    d_waddr = idx_r[DA_W-1:0];
    d_wdata = '{vis: 1'b0, d: DMAX};
    case (cmd.act)
      ACT_SCAN, ACT_MAX: d_re = idx_r < two_n;
      ACT_SLOT: begin
        d_re    = s_act;
        d_raddr = DA_W'(s_tgt);
      end
      ACT_INIT_WR: begin
        d_we    = 1'b1;
        d_wdata = '{vis: 1'b0, d: (idx_r < n_i) ? DW'(sc_q) : DMAX};
      end
      ACT_MARK: begin
        d_we    = 1'b1;
        d_waddr = pick_r;
        d_wdata = '{vis: 1'b1, d: pd_r};
      end
      ACT_RLX: begin
        d_we    = !dq.vis && (cand_r < dq.d);
        d_waddr = tgt_r;
        d_wdata = '{vis: 1'b0, d: cand_r};
      end
      default: d_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dist_mem[d_waddr] <= d_wdata;
    end
    if (d_re) begin
      dq <= dist_mem[d_raddr];
    end
  end

  // Edge store: append on load, fetch during relaxation
  always_ff @(posedge clk) begin
    if (cmd.act == ACT_LOAD_EDGE && 32'(ecnt_r) < MAX_EDGES) begin
      edge_mem[ecnt_r[EA_W-1:0]] <= '{a: in_data.node_a, b: in_data.node_b,
                                      w: in_data.weight};
    end
    if (cmd.act == ACT_EFETCH) begin
      eq <= edge_mem[e_r[EA_W-1:0]];
    end
  end

  // Start cost store
  always_ff @(posedge clk) begin
    if (cmd.act == ACT_LOAD_COST && 32'(in_data.node_a) < MAX_NODES) begin
      cost_mem[NODE_W'(in_data.node_a)] <= in_data.weight;
    end
    if (cmd.act == ACT_INIT_RD) begin
      sc_q <= cost_mem[idx_r[NODE_W-1:0]];
    end
  end

  // Saturate the result to the output width, or zero-extend it if it fits
  generate
    if (DW > OUT_W) begin : g_sat
      assign best_o = (|best_r[DW-1:OUT_W]) ? '1 : best_r[OUT_W-1:0];
    end else begin : g_ext
      assign best_o = OUT_W'(best_r);
    end
  endgenerate

  // Sweep, pick and relax bookkeeping
  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_INIT_CLR: idx_r <= '0;
      ACT_INIT_WR:  idx_r <= idx_r + IW'(1);
      ACT_SCAN_CLR: begin
        idx_r   <= '0;
        vld_d_r <= 1'b0;
        pd_r    <= DMAX;
        found_r <= 1'b0;
      end
      ACT_SCAN: begin
        vld_d_r <= idx_r < two_n;
        idx_d_r <= idx_r[DA_W-1:0];
        if (idx_r < two_n) begin
          idx_r <= idx_r + IW'(1);
        end
        if (vld_d_r && !dq.vis && dq.d < pd_r) begin
          pd_r    <= dq.d;
          pick_r  <= idx_d_r;
          found_r <= 1'b1;
        end
      end
      ACT_MARK:   e_r <= '0;
      ACT_EFETCH: begin
        e_r    <= e_r + EC_W'(1);
        slot_r <= '0;
      end
      ACT_SLOT: begin
        slot_r <= slot_r + 3'd1;
        tgt_r  <= DA_W'(s_tgt);
        cand_r <= s_cand;
      end
      ACT_MAX_CLR: begin
        idx_r   <= n_i;
        vld_d_r <= 1'b0;
        best_r  <= '0;
      end
      ACT_MAX: begin
        vld_d_r <= idx_r < two_n;
        if (idx_r < two_n) begin
          idx_r <= idx_r + IW'(1);
        end
        if (vld_d_r && dq.d > best_r) begin
          best_r <= dq.d;
        end
      end
      ACT_DONE: begin
        out_data_r <= '{longest_distance: best_o, edges_dropped: ovf_r};
      end
      default: vld_d_r <= vld_d_r;
    endcase
  end

  // Control state: config, edge count, overflow, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r      <= NODE_CNT_RST;
      ecnt_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        node_r <= cfg_data;
      end
      if (cmd.act == ACT_LOAD_EDGE) begin
        if (32'(ecnt_r) < MAX_EDGES) begin
          ecnt_r <= ecnt_r + EC_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.act == ACT_DONE) begin
        out_valid_r <= 1'b1;
        ecnt_r      <= '0;
        ovf_r       <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.out_busy   = out_valid_r;
  assign stat.init_last  = (idx_r + IW'(1)) == two_n;
  assign stat.sweep_done = (idx_r == two_n) && !vld_d_r;
  assign stat.found      = found_r;
  assign stat.edges_done = e_r == ecnt_r;
  assign stat.slot_act   = s_act;
  assign stat.slot_last  = slot_r == 3'd5;
  assign stat.slot_end   = slot_r == 3'd6;

endmodule

// ===== src/tlsp_checker.sv =====
`include "two_layer_shortest_path_max_top_defines.svh"

module tlsp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input tlsp_pkg::in_t                   in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input tlsp_pkg::out_t                  out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [tlsp_pkg::NODE_CNT_W-1:0] cfg_data
);
  import tlsp_pkg::*;

  // Hold a stalled result
  `TLSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  // A run request makes the block busy
  `TLSP_ASSERT_NEXT(a_run_busy, in_valid && in_ready && in_data.operation == OP_RUN, !in_ready, "input taken during run")
  // A result appears only at the end of a run
  `TLSP_ASSERT_NOW(a_out_after_run, $rose(out_valid), $past(!in_ready), "result without a run")
  // A taken result is not repeated
  `TLSP_ASSERT_NEXT(a_out_once, out_valid && out_ready, !out_valid, "result repeated")

endmodule

bind two_layer_shortest_path_max_top tlsp_checker u_chk (.*);
